FILE: rtl/core/idpa_pkg.sv
// Shared types and codes for the incremental PID with deadband and anti-windup.
// No dependencies; imported by every module of the block.
package idpa_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_DEAD_BAND = 3'd3,
        REG_OUT_MIN   = 3'd4,
        REG_OUT_MAX   = 3'd5,
        REG_LIMIT_EN  = 3'd6
    } cfg_reg_t;

    // Load enables for the two register stages of a gain multiplier.
    typedef struct packed {
        logic load_a;   // capture raw magnitude product
        logic load_b;   // capture scaled, saturated term
    } pipe_ctl_t;

endpackage

FILE: rtl/core/idpa_err.sv
// Error stage: deadband test, error history and the P and D differences.
// Depends on idpa_pkg.
module idpa_err
    import idpa_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [DATA_WIDTH-1:0] set_point,
    input  logic [DATA_WIDTH-1:0] measured,
    input  logic [DATA_WIDTH-2:0] dead_band,
    output logic [DATA_WIDTH-1:0] err,
    output logic [DATA_WIDTH-1:0] err_p_diff,
    output logic [DATA_WIDTH-1:0] err_d_diff
);

    localparam int DW = DATA_WIDTH;
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    logic [DW-1:0] prev_reg, prev_next;
    logic [DW-1:0] prev2_reg, prev2_next;
    logic [DW-1:0] err_reg, pdiff_reg, ddiff_reg;

    logic signed [DW:0]   diff;
    logic        [DW:0]   mag;
    logic                 in_band;
    logic        [DW-1:0] e_sat, e_cur, e_one;
    logic signed [DW:0]   p_raw;
    logic        [DW-1:0] p_sat;
    logic signed [DW+2:0] d_raw;
    logic        [DW-1:0] d_sat;

    // Form the error, apply the deadband and build both differences
    always_comb
    begin
        diff    = $signed({set_point[DW-1], set_point}) - $signed({measured[DW-1], measured});
        mag     = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);
        in_band = (mag <= (DW+1)'(dead_band));

        if (diff[DW] != diff[DW-1])
            e_sat = diff[DW] ? MINV : MAXV;
        else
            e_sat = diff[DW-1:0];

        e_cur = in_band ? '0 : e_sat;
        e_one = in_band ? '0 : prev_reg;

        p_raw = $signed({e_cur[DW-1], e_cur}) - $signed({e_one[DW-1], e_one});
        if (p_raw[DW] != p_raw[DW-1])
            p_sat = p_raw[DW] ? MINV : MAXV;
        else
            p_sat = p_raw[DW-1:0];

        d_raw = $signed({{3{e_cur[DW-1]}}, e_cur})
              - $signed({{2{e_one[DW-1]}}, e_one, 1'b0})
              + $signed({{3{prev2_reg[DW-1]}}, prev2_reg});
        if ((&d_raw[DW+2:DW-1]) || (~|d_raw[DW+2:DW-1]))
            d_sat = d_raw[DW-1:0];
        else
            d_sat = d_raw[DW+2] ? MINV : MAXV;

        prev_next  = load ? e_cur : prev_reg;
        prev2_next = load ? e_one : prev2_reg;
    end

    // Shift the error history once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            prev2_reg <= '0;
        end
        else
        begin
            prev_reg  <= prev_next;
            prev2_reg <= prev2_next;
        end
    end

    // Hold the stage outputs for the multipliers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg   <= e_cur;
            pdiff_reg <= p_sat;
            ddiff_reg <= d_sat;
        end
    end

    assign err        = err_reg;
    assign err_p_diff = pdiff_reg;
    assign err_d_diff = ddiff_reg;

endmodule

FILE: rtl/core/idpa_fmul.sv
// Fixed-point gain multiplier: exact magnitude product, truncating shift, saturation.
// Two register stages; depends on idpa_pkg for the stage load enables.
module idpa_fmul
    import idpa_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                  clk,
    input  pipe_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] gain,
    input  logic [DATA_WIDTH-1:0] operand,
    output logic [DATA_WIDTH-1:0] term
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic [PW-1:0] LIM_POS = PW'(MAXV);
    localparam logic [PW-1:0] LIM_NEG = PW'(MINV);

    logic [DW-1:0] ua, ub;
    logic          neg;
    logic [PW-1:0] prod_reg;
    logic          neg_reg;
    logic [PW-1:0] shifted;
    logic [DW-1:0] mag_trunc;
    logic [DW-1:0] term_next;
    logic [DW-1:0] term_reg;

    // Take magnitudes and the sign of the product
    always_comb
    begin
        ua  = gain[DW-1]    ? (-gain)    : gain;
        ub  = operand[DW-1] ? (-operand) : operand;
        neg = gain[DW-1] ^ operand[DW-1];
    end

    // Capture the full magnitude product
    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            prod_reg <= PW'(ua) * PW'(ub);
            neg_reg  <= neg;
        end
    end

    // Drop the fraction bits, saturate and restore the sign
    always_comb
    begin
        shifted   = prod_reg >> FRAC_BITS;
        mag_trunc = shifted[DW-1:0];
        if (shifted >= (neg_reg ? LIM_NEG : LIM_POS))
            term_next = neg_reg ? MINV : MAXV;
        else
            term_next = neg_reg ? (-mag_trunc) : mag_trunc;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_b)
            term_reg <= term_next;
    end

    assign term = term_reg;

endmodule

FILE: rtl/core/idpa_out.sv
// Output stage: saturating sum of the three terms and the output-bound check.
// Depends on idpa_pkg.
module idpa_out
    import idpa_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  load,
    input  logic [DATA_WIDTH-1:0] p_term,
    input  logic [DATA_WIDTH-1:0] i_term,
    input  logic [DATA_WIDTH-1:0] d_term,
    input  logic [DATA_WIDTH-1:0] current_output,
    input  logic [DATA_WIDTH-1:0] out_min,
    input  logic [DATA_WIDTH-1:0] out_max,
    input  logic                  limit_enable,
    output logic [DATA_WIDTH-1:0] increment,
    output logic                  limit_hit
);

    localparam int DW = DATA_WIDTH;
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    logic signed [DW+1:0] sum;
    logic        [DW-1:0] inc_sat;
    logic signed [DW:0]   total;
    logic                 hit;
    logic        [DW-1:0] inc_next;
    logic        [DW-1:0] inc_reg;
    logic                 hit_reg;

    // Add the terms, saturate, then test the projected output against the bounds
    always_comb
    begin
        sum = $signed({{2{p_term[DW-1]}}, p_term})
            + $signed({{2{i_term[DW-1]}}, i_term})
            + $signed({{2{d_term[DW-1]}}, d_term});
        if ((&sum[DW+1:DW-1]) || (~|sum[DW+1:DW-1]))
            inc_sat = sum[DW-1:0];
        else
            inc_sat = sum[DW+1] ? MINV : MAXV;

        total = $signed({current_output[DW-1], current_output})
              + $signed({inc_sat[DW-1], inc_sat});
        hit   = limit_enable
              && ((total >= $signed({out_max[DW-1], out_max}))
               || (total <= $signed({out_min[DW-1], out_min})));

        inc_next = hit ? p_term : inc_sat;
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            inc_reg <= inc_next;
            hit_reg <= hit;
        end
    end

    assign increment = inc_reg;
    assign limit_hit = hit_reg;

endmodule

FILE: rtl/core/incremental_pid_deadband_antiwindup.sv
// Incremental PID, signed fixed point, with deadband and output-bound anti-windup.
// An accepted word passes the input, error, product, term and result registers.
// Throughput: one word per cycle unless m_tready stalls; error history updates
// in the error stage, and the gain multipliers are pipelined over two stages.
// Reset (rst_n low, asynchronous): pipeline empty, error history zero,
// registers at their defaults. Depends on idpa_pkg and the idpa_* modules.
module incremental_pid_deadband_antiwindup
    import idpa_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // slave side
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // tdata: set_point, measured, current_output (lowest bits first)
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    // master side
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // tdata: increment
    output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata,
    // tuser: limit_hit
    output logic                         m_tuser,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data
);

    localparam int DW     = DATA_WIDTH;
    localparam int OUT_W  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int NSTG   = 5;
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam longint DB_RESET_VAL = ((longint'(1) << FRAC_BITS) * 2 + 50) / 100;
    localparam logic [DW-2:0] DB_RESET = (DW-1)'(DB_RESET_VAL);

    // Configuration registers
    logic [DW-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DW-2:0] dead_band_reg;
    logic [DW-1:0] out_min_reg, out_max_reg;
    logic          limit_en_reg;

    // Stage valid bits: 0 input, 1 error, 2 product, 3 term, 4 result
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG-1:0] rdy;

    // Input word and current output carried along the pipe
    logic [DW-1:0] sp_reg, ms_reg;
    logic [DW-1:0] cur0_reg, cur1_reg, cur2_reg, cur3_reg;

    logic [DW-1:0] err, err_p_diff, err_d_diff;
    logic [DW-1:0] p_term, i_term, d_term;
    logic [DW-1:0] increment;
    logic          limit_hit;
    pipe_ctl_t     mul_ctl;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            dead_band_reg <= DB_RESET;
            out_min_reg   <= MINV;
            out_max_reg   <= MAXV;
            limit_en_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:    gain_p_reg    <= cfg_data;
                REG_GAIN_I:    gain_i_reg    <= cfg_data;
                REG_GAIN_D:    gain_d_reg    <= cfg_data;
                REG_DEAD_BAND: dead_band_reg <= cfg_data[DW-2:0];
                REG_OUT_MIN:   out_min_reg   <= cfg_data;
                REG_OUT_MAX:   out_max_reg   <= cfg_data;
                REG_LIMIT_EN:  limit_en_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Per-stage ready: a stage can load when it is empty or its contents move on
    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];

        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Capture the input word and advance the current output alongside
    always_ff @(posedge clk)
    begin
        if (s_tvalid && rdy[0])
        begin
            sp_reg   <= s_tdata[DW-1:0];
            ms_reg   <= s_tdata[2*DW-1:DW];
            cur0_reg <= s_tdata[3*DW-1:2*DW];
        end
        if (rdy[1] && vld_reg[0])
            cur1_reg <= cur0_reg;
        if (mul_ctl.load_a)
            cur2_reg <= cur1_reg;
        if (mul_ctl.load_b)
            cur3_reg <= cur2_reg;
    end

    assign mul_ctl.load_a = rdy[2] && vld_reg[1];
    assign mul_ctl.load_b = rdy[3] && vld_reg[2];

    idpa_err #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_err (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (rdy[1] && vld_reg[0]),
        .set_point  (sp_reg),
        .measured   (ms_reg),
        .dead_band  (dead_band_reg),
        .err        (err),
        .err_p_diff (err_p_diff),
        .err_d_diff (err_d_diff)
    );

    idpa_fmul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul_p (
        .clk     (clk),
        .ctl     (mul_ctl),
        .gain    (gain_p_reg),
        .operand (err_p_diff),
        .term    (p_term)
    );

    idpa_fmul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul_i (
        .clk     (clk),
        .ctl     (mul_ctl),
        .gain    (gain_i_reg),
        .operand (err),
        .term    (i_term)
    );

    idpa_fmul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul_d (
        .clk     (clk),
        .ctl     (mul_ctl),
        .gain    (gain_d_reg),
        .operand (err_d_diff),
        .term    (d_term)
    );

    idpa_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .clk            (clk),
        .load           (rdy[4] && vld_reg[3]),
        .p_term         (p_term),
        .i_term         (i_term),
        .d_term         (d_term),
        .current_output (cur3_reg),
        .out_min        (out_min_reg),
        .out_max        (out_max_reg),
        .limit_enable   (limit_en_reg),
        .increment      (increment),
        .limit_hit      (limit_hit)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = OUT_W'(increment);
    assign m_tuser  = limit_hit;

endmodule
